// ----- hw/rtl/gated_activation_unit_assert.svh -----
// Assertion macros for the gated activation unit.
// Used by the top level; no other dependencies.
`ifndef GATED_ACTIVATION_UNIT_ASSERT_SVH
`define GATED_ACTIVATION_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define GAU_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gated activation unit: check failed");

// next-cycle implication, off during reset
`define GAU_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gated activation unit: check failed");

`endif

// ----- hw/rtl/gau_pkg.sv -----
// Shared types, constants and rounding helper for the gated activation unit.
// No dependencies; imported by the interfaces, the table and the top level.
`default_nettype none

package gau_pkg;

    localparam int LUT_ENTRIES_DFLT = 256;

    typedef logic signed [15:0] t_q88;
    typedef logic signed [31:0] t_q1616;

    typedef enum logic {
        ACT_SILU = 1'b0,
        ACT_GELU = 1'b1
    } t_act_mode;

    // one table row: point value and slope to the next point, both Q2.30
    typedef struct packed {
        logic signed [31:0] base;
        logic signed [31:0] delta;
    } t_lut_word;

    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
    localparam logic [27:0]        K1_Q32  = 28'd192049463;
    localparam logic [19:0]        K0_Q20  = 20'd836643;

    // arithmetic shift right, rounding half away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                    input int unsigned sh);
        logic [63:0] m;
        logic [63:0] half;
        half = 64'd1 << (sh - 1);
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + half) >> sh;
        return v[63] ? -signed'(m) : signed'(m);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gau_in_if.sv -----
// Input channel of the gated activation unit: gate and up values.
// Depends on gau_pkg.
`default_nettype none

interface gau_in_if;
    import gau_pkg::*;

    logic valid;
    logic ready;
    t_q88 gate_value;
    t_q88 up_value;

    modport source (output valid, output gate_value, output up_value, input ready);
    modport sink   (input valid, input gate_value, input up_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gau_out_if.sv -----
// Output channel of the gated activation unit: gated result word.
// Depends on gau_pkg.
`default_nettype none

interface gau_out_if;
    import gau_pkg::*;

    logic   valid;
    logic   ready;
    t_q1616 gated_value;

    modport source (output valid, output gated_value, input ready);
    modport sink   (input valid, input gated_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gau_lut.sv -----
// Sigmoid / tanh interpolation ROM with registered read, contents built at elaboration.
// Depends on gau_pkg.
`default_nettype none

module gau_lut #(
    parameter int LUT_ENTRIES = gau_pkg::LUT_ENTRIES_DFLT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire gau_pkg::t_act_mode               i_mode,
    input  wire logic [$clog2(LUT_ENTRIES)-1:0]   i_seg,
    output gau_pkg::t_lut_word                    o_word
);
    import gau_pkg::*;

    localparam int SEG_W     = $clog2(LUT_ENTRIES);
    localparam int SEG_SPAN  = 1 << SEG_W;
    localparam int ROM_DEPTH = 2 * SEG_SPAN;

    typedef logic [63:0] t_rom [ROM_DEPTH];

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f), f in [0, 1], Q30, truncated Taylor series
    function automatic logic signed [63:0] exp_neg_unit(input logic [63:0] f);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = 64'(ONE_Q30);
        sum  = ONE_Q30;
        for (int k = 1; k <= 24; k++) begin
            term = udiv((term * f) >> 30, 64'(k));
            if (k[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return sum;
    endfunction

    // exp(-t), t >= 0, Q30
    function automatic logic signed [63:0] exp_neg(input logic signed [63:0] t);
        logic signed [63:0] e1;
        logic signed [63:0] r;
        logic [63:0]        n;
        e1 = exp_neg_unit(64'(ONE_Q30));
        r  = exp_neg_unit(64'(t & (ONE_Q30 - 64'sd1)));
        n  = 64'(t >>> 30);
        for (int j = 0; j < 32; j++) begin
            if (64'(j) < n) begin
                r = rnd_shr(r * e1, 30);
            end
        end
        return r;
    endfunction

    function automatic t_rom build_rom();
        logic signed [63:0] sig_t [LUT_ENTRIES+1];
        logic signed [63:0] tnh_t [LUT_ENTRIES+1];
        logic signed [63:0] num;
        logic signed [63:0] mag;
        logic signed [63:0] t;
        logic signed [63:0] e;
        logic signed [63:0] den;
        logic signed [63:0] sp;
        logic signed [63:0] e2;
        logic signed [63:0] den2;
        logic signed [63:0] tp;
        logic signed [63:0] d_sig;
        logic signed [63:0] d_tnh;
        t_rom               rom;
        for (int i = 0; i <= LUT_ENTRIES; i++) begin
            num  = 64'(16 * i) - 64'(8 * LUT_ENTRIES);
            mag  = (num < 0) ? -num : num;
            t    = signed'(udiv(64'(mag) << 30, 64'(LUT_ENTRIES)));
            e    = exp_neg(t);
            den  = ONE_Q30 + e;
            sp   = signed'(udiv((64'd1 << 60) + 64'(den >>> 1), 64'(den)));
            e2   = exp_neg(t <<< 1);
            den2 = ONE_Q30 + e2;
            tp   = signed'(udiv(64'((ONE_Q30 - e2) <<< 30) + 64'(den2 >>> 1), 64'(den2)));
            sig_t[i] = (num < 0) ? ONE_Q30 - sp : sp;
            tnh_t[i] = (num < 0) ? -tp : tp;
        end
        for (int j = 0; j < ROM_DEPTH; j++) begin
            rom[j] = '0;
        end
        for (int j = 0; j < LUT_ENTRIES; j++) begin
            d_sig = sig_t[j+1] - sig_t[j];
            d_tnh = tnh_t[j+1] - tnh_t[j];
            rom[j]            = {sig_t[j][31:0], d_sig[31:0]};
            rom[SEG_SPAN + j] = {tnh_t[j][31:0], d_tnh[31:0]};
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    t_lut_word r_word;

    // sigmoid rows in the lower half, tanh rows in the upper half
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= t_lut_word'(ROM[{i_mode, i_seg}]);
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ----- hw/rtl/gated_activation_unit.sv -----
// Gated activation unit: act(gate) * up, SiLU or tanh-GELU, 13-stage pipeline.
// Depends on gau_pkg, gau_in_if, gau_out_if, gau_lut and the assertion header.
//
// Usage:
//  - i_in carries one word per item: gate_value and up_value, signed Q8.8.
//  - o_out returns one word per item: gated_value, signed Q16.16, in order.
//  - i_cfg_we / i_cfg_wdata write act_mode (0 SiLU, 1 GELU); write it only
//    while the pipeline is empty. Each word samples the mode when accepted.
//  - Pipeline: 13 register stages; a word accepted on i_in passes through
//    them in order and leaves on o_out.
//  - Throughput: one word per cycle while o_out is not stalled, set by the fully pipelined datapath
//    (multiplies spread over separate stages, single-read ROM stage).
//  - Stalls: each stage holds its word while the next is full and stalled;
//    empty stages keep filling, so i_in.ready stays high until all 13
//    stages hold a word while o_out.ready is low.
//  - Reset (i_rst_n low, synchronous): all stages empty, act_mode = SiLU.
//    The ROM is constant, so no fill time follows reset.
`default_nettype none

`include "gated_activation_unit_assert.svh"

module gated_activation_unit #(
    parameter int LUT_ENTRIES = gau_pkg::LUT_ENTRIES_DFLT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    gau_in_if.sink     i_in,
    gau_out_if.source  o_out
);
    import gau_pkg::*;

    localparam int NSTG  = 13;
    localparam int SEG_W = $clog2(LUT_ENTRIES);
    localparam int CNT_W = $clog2(LUT_ENTRIES + 1);
    localparam int POS_W = 20 + CNT_W;

    // config
    t_act_mode r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ACT_SILU;
        end else if (i_cfg_we) begin
            r_mode <= t_act_mode'(i_cfg_wdata);
        end
    end

    // stage valids and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   en;
    logic [NSTG-1:0] vin;

    always_comb begin
        en[NSTG] = o_out.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign vin = {r_vld[NSTG-2:0], i_in.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (en[NSTG-1:0] & vin) | (~en[NSTG-1:0] & r_vld);
        end
    end

    assign i_in.ready = en[0];

    // stage registers
    t_q88               r0_g, r0_u;
    t_act_mode          r0_mode;
    t_q88               r1_g;
    t_act_mode          r1_mode;
    logic signed [31:0] r1_gu;
    logic [30:0]        r1_g2;
    t_q88               r2_g;
    t_act_mode          r2_mode;
    logic signed [31:0] r2_gu;
    logic [58:0]        r2_k1p;
    t_q88               r3_g;
    t_act_mode          r3_mode;
    logic signed [31:0] r3_gu;
    logic signed [42:0] r3_gi;
    t_q88               r4_g;
    t_act_mode          r4_mode;
    logic signed [31:0] r4_gu;
    logic signed [22:0] r4_x;
    t_q88               r5_g;
    t_act_mode          r5_mode;
    logic signed [31:0] r5_gu;
    logic signed [43:0] r5_zp;
    t_act_mode          r6_mode;
    logic signed [31:0] r6_gu;
    logic [20:0]        r6_a;
    t_act_mode          r7_mode;
    logic signed [31:0] r7_gu;
    logic [SEG_W-1:0]   r7_seg;
    logic [20:0]        r7_frac;
    t_act_mode          r8_mode;
    logic signed [31:0] r8_gu;
    logic [20:0]        r8_frac;
    t_lut_word          lut_word;
    t_act_mode          r9_mode;
    logic signed [31:0] r9_gu;
    logic signed [31:0] r9_base;
    logic signed [53:0] r9_dp;
    logic signed [31:0] r10_gu;
    logic [31:0]        r10_fac;
    logic signed [63:0] r11_prod;
    t_q1616             r12_res;

    // next values
    logic signed [31:0] n1_gu;
    logic signed [31:0] n1_sq;
    logic [26:0]        n3_inner;
    logic signed [42:0] n3_gi;
    logic signed [63:0] n4_xf;
    logic signed [22:0] n4_x;
    logic signed [43:0] n5_zp;
    logic signed [63:0] n6_z;
    logic signed [24:0] n6_arg;
    logic [20:0]        n6_a;
    logic [POS_W-1:0]   n7_pos;
    logic [CNT_W-1:0]   n7_segr;
    logic [SEG_W-1:0]   n7_seg;
    logic [20:0]        n7_frac;
    logic signed [63:0] n10_rnd;
    logic signed [31:0] n10_act;
    logic signed [32:0] n10_sum;
    logic [31:0]        n10_fac;
    logic signed [63:0] n12_res;

    always_comb begin
        n1_gu = 32'(r0_g) * 32'(r0_u);
        n1_sq = 32'(r0_g) * 32'(r0_g);

        // 1 + k1*g^2 in Q.16
        n3_inner = 27'(32'd65536) + 27'((r2_k1p + (59'd1 << 31)) >> 32);
        n3_gi    = 43'(r2_g) * 43'(signed'({1'b0, n3_inner}));

        // beyond +-2^21 the tanh argument saturates anyway
        n4_xf = rnd_shr(64'(r3_gi), 8);
        if (n4_xf > 64'sd2097152) begin
            n4_x = 23'sd2097152;
        end else if (n4_xf < -64'sd2097152) begin
            n4_x = -23'sd2097152;
        end else begin
            n4_x = 23'(n4_xf);
        end

        n5_zp = 44'(r4_x) * 44'(signed'({1'b0, K0_Q20}));

        n6_z = rnd_shr(64'(r5_zp), 20);
        if (r5_mode == ACT_GELU) begin
            n6_arg = 25'(n6_z);
        end else begin
            n6_arg = 25'(signed'({r5_g, 8'd0}));
        end
        if (n6_arg > 25'sd524288) begin
            n6_arg = 25'sd524288;
        end else if (n6_arg < -25'sd524288) begin
            n6_arg = -25'sd524288;
        end
        n6_a = 21'(n6_arg + 25'sd524288);

        // table position: segment index and 20-bit fraction
        n7_pos  = POS_W'(r6_a) * POS_W'(LUT_ENTRIES);
        n7_segr = n7_pos[POS_W-1:20];
        if (n7_segr >= CNT_W'(LUT_ENTRIES)) begin
            n7_seg  = SEG_W'(LUT_ENTRIES - 1);
            n7_frac = 21'h100000;
        end else begin
            n7_seg  = n7_segr[SEG_W-1:0];
            n7_frac = {1'b0, n7_pos[19:0]};
        end

        // SiLU factor 2*s pairs with the common >>31 at the end
        n10_rnd = rnd_shr(64'(r9_dp), 20);
        n10_act = r9_base + 32'(n10_rnd);
        n10_sum = 33'(n10_act) + 33'(ONE_Q30);
        if (r9_mode == ACT_GELU) begin
            n10_fac = n10_sum[31:0];
        end else begin
            n10_fac = {n10_act[30:0], 1'b0};
        end

        n12_res = rnd_shr(r11_prod, 31);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_g    <= i_in.gate_value;
            r0_u    <= i_in.up_value;
            r0_mode <= r_mode;
        end
        if (en[1]) begin
            r1_g    <= r0_g;
            r1_mode <= r0_mode;
            r1_gu   <= n1_gu;
            r1_g2   <= n1_sq[30:0];
        end
        if (en[2]) begin
            r2_g    <= r1_g;
            r2_mode <= r1_mode;
            r2_gu   <= r1_gu;
            r2_k1p  <= 59'(r1_g2) * 59'(K1_Q32);
        end
        if (en[3]) begin
            r3_g    <= r2_g;
            r3_mode <= r2_mode;
            r3_gu   <= r2_gu;
            r3_gi   <= n3_gi;
        end
        if (en[4]) begin
            r4_g    <= r3_g;
            r4_mode <= r3_mode;
            r4_gu   <= r3_gu;
            r4_x    <= n4_x;
        end
        if (en[5]) begin
            r5_g    <= r4_g;
            r5_mode <= r4_mode;
            r5_gu   <= r4_gu;
            r5_zp   <= n5_zp;
        end
        if (en[6]) begin
            r6_mode <= r5_mode;
            r6_gu   <= r5_gu;
            r6_a    <= n6_a;
        end
        if (en[7]) begin
            r7_mode <= r6_mode;
            r7_gu   <= r6_gu;
            r7_seg  <= n7_seg;
            r7_frac <= n7_frac;
        end
        if (en[8]) begin
            r8_mode <= r7_mode;
            r8_gu   <= r7_gu;
            r8_frac <= r7_frac;
        end
        if (en[9]) begin
            r9_mode <= r8_mode;
            r9_gu   <= r8_gu;
            r9_base <= lut_word.base;
            r9_dp   <= 54'(lut_word.delta) * 54'(signed'({1'b0, r8_frac}));
        end
        if (en[10]) begin
            r10_gu  <= r9_gu;
            r10_fac <= n10_fac;
        end
        if (en[11]) begin
            r11_prod <= 64'(r10_gu) * 64'(signed'({1'b0, r10_fac}));
        end
        if (en[12]) begin
            r12_res <= n12_res[31:0];
        end
    end

    // stage 8 register sits inside the ROM
    gau_lut #(
        .LUT_ENTRIES (LUT_ENTRIES)
    ) u_lut (
        .i_clk  (i_clk),
        .i_en   (en[8]),
        .i_mode (r7_mode),
        .i_seg  (r7_seg),
        .o_word (lut_word)
    );

    assign o_out.valid       = r_vld[NSTG-1];
    assign o_out.gated_value = r12_res;

    `GAU_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, (&r_vld) && !o_out.ready, !i_in.ready)
    `GAU_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0])
    `GAU_ASSERT_IMPL(a_seg_range, i_clk, i_rst_n, r_vld[7], (r7_seg <= SEG_W'(LUT_ENTRIES - 1)) && (r7_frac <= 21'h100000))
    `GAU_ASSERT_IMPL(a_fac_range, i_clk, i_rst_n, r_vld[10], r10_fac <= 32'h8000_0000)

endmodule

`default_nettype wire

// ----- bench/gated_activation_unit_tb.sv -----
// Testbench for gated_activation_unit: drives gate/up words through random idling
// and stalls, predicts act(gate)*up bit-exactly and checks every result word.
// Depends on gau_pkg, gau_in_if, gau_out_if and the gated_activation_unit RTL.
module gated_activation_unit_tb;
    import gau_pkg::*;

    localparam int     TAB_N    = LUT_ENTRIES_DFLT;
    localparam longint UNIT_Q30 = 64'sd1 << 30;
    localparam longint ARG_LIM  = 64'sd8 << 16;
    localparam longint K1_GELU  = 64'sd192049463;
    localparam longint K0_GELU  = 64'sd836643;

    typedef struct packed {
        t_q88 gate;
        t_q88 up;
    } t_gate_up;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    gau_in_if  in_ch ();
    gau_out_if out_ch ();

    gated_activation_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #10 clk = ~clk;

    longint     sig_tab [0:TAB_N];
    longint     tanh_tab[0:TAB_N];
    t_act_mode  mode_copy = ACT_SILU;
    t_gate_up   pending_pairs[$];
    t_q1616     gated_expected[$];
    bit         in_took = 1'b0;
    int         mismatches = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;

    t_q88 corner_gate[12] = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                              16'sd2048, -16'sd2048, 16'sd2049, -16'sd2049, 16'sd1,
                              -16'sd1, 16'sd256};
    t_q88 corner_up[12]   = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                              16'sd256, 16'sd256, -16'sd256, 16'sd256, 16'sd1,
                              -16'sd1, 16'sd32767};

    // shift right, rounding half away from zero
    function automatic longint round_shift(longint v, int sh);
        longint half;
        half = 64'sd1 << (sh - 1);
        if (v >= 0)
            return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    // exp(-f), f in [0, 1], Q30 Taylor series
    function automatic longint exp_frac(longint f);
        longint term;
        longint sum;
        term = UNIT_Q30;
        sum = UNIT_Q30;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >>> 30) / k;
            sum += (k % 2) ? -term : term;
        end
        return sum;
    endfunction

    function automatic longint exp_decay(longint t);
        longint e1;
        longint r;
        longint n;
        e1 = exp_frac(UNIT_Q30);
        r = exp_frac(t & (UNIT_Q30 - 1));
        n = t >>> 30;
        while (n > 0) begin
            r = round_shift(r * e1, 30);
            n--;
        end
        return r;
    endfunction

    function automatic void fill_tables();
        longint num, mag, t, e, den, sp, e2, den2, tp;
        for (int i = 0; i <= TAB_N; i++) begin
            num = 64'sd16 * i - 64'sd8 * TAB_N;
            mag = num < 0 ? -num : num;
            t = (mag <<< 30) / TAB_N;
            e = exp_decay(t);
            den = UNIT_Q30 + e;
            sp = ((64'sd1 <<< 60) + den / 2) / den;
            e2 = exp_decay(2 * t);
            den2 = UNIT_Q30 + e2;
            tp = (((UNIT_Q30 - e2) <<< 30) + den2 / 2) / den2;
            sig_tab[i] = num < 0 ? UNIT_Q30 - sp : sp;
            tanh_tab[i] = num < 0 ? -tp : tp;
        end
    endfunction

    // interpolated table lookup, argument Q.16 clamped to +/-8, result Q30
    function automatic longint table_read(bit use_tanh, longint arg);
        longint pos, seg, frac, lo, hi;
        if (arg < -ARG_LIM) arg = -ARG_LIM;
        if (arg > ARG_LIM) arg = ARG_LIM;
        pos = (arg + ARG_LIM) * TAB_N;
        seg = pos >>> 20;
        frac = pos & 64'hFFFFF;
        if (seg >= TAB_N) begin
            seg = TAB_N - 1;
            frac = 64'sd1 << 20;
        end
        lo = use_tanh ? tanh_tab[int'(seg)] : sig_tab[int'(seg)];
        hi = use_tanh ? tanh_tab[int'(seg) + 1] : sig_tab[int'(seg) + 1];
        return lo + round_shift((hi - lo) * frac, 20);
    endfunction

    function automatic t_q1616 gated_product(t_q88 g_in, t_q88 u_in, t_act_mode m);
        longint g, u, gu, inner, z, res;
        g = g_in;
        u = u_in;
        gu = g * u;
        if (m == ACT_SILU) begin
            res = round_shift(gu * table_read(1'b0, g * 256), 30);
        end else begin
            inner = (64'sd1 << 16) + round_shift(g * g * K1_GELU, 32);
            z = round_shift(round_shift(g * inner, 8) * K0_GELU, 20);
            res = round_shift(gu * (UNIT_Q30 + table_read(1'b1, z)), 31);
        end
        return res[31:0];
    endfunction

    // sender and receiver, both changing on the falling edge
    always @(negedge clk) begin : drive
        t_gate_up word;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            if (!in_ch.valid || in_took) begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    word = pending_pairs.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.gate_value <= word.gate;
                    in_ch.up_value <= word.up;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : watch
        t_q1616 want;
        in_took = 1'b0;
        if (!rst_n) begin
            mode_copy = ACT_SILU;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                in_took = 1'b1;
                gated_expected.push_back(gated_product(in_ch.gate_value, in_ch.up_value,
                                                       mode_copy));
            end
            if (cfg_we)
                mode_copy = t_act_mode'(cfg_wdata);
            if (out_ch.valid && out_ch.ready) begin
                if (gated_expected.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %h", $time,
                             out_ch.gated_value);
                    mismatches++;
                end else begin
                    want = gated_expected.pop_front();
                    if (out_ch.gated_value !== want) begin
                        $display("%0t: gated_value expected %h, got %h", $time, want,
                                 out_ch.gated_value);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic write_mode(t_act_mode m);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // waits until every queued word has been sent and the pipeline has returned every word
    task automatic drain_all();
        while (pending_pairs.size() != 0 || in_ch.valid || gated_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_random(int n);
        t_gate_up p;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: p.gate = t_q88'($urandom);
                1: p.gate = t_q88'(int'($urandom_range(0, 5200)) - 2600);
                2: p.gate = t_q88'(int'($urandom_range(0, 1200)) - 600);
                default: p.gate = t_q88'(($urandom_range(0, 1) ? 2047 : -2049) +
                                         int'($urandom_range(0, 2)));
            endcase
            if ($urandom_range(0, 3) == 0)
                p.up = t_q88'(int'($urandom_range(0, 1024)) - 512);
            else
                p.up = t_q88'($urandom);
            pending_pairs.push_back(p);
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.gate_value = '0;
        in_ch.up_value = '0;
        out_ch.ready = 1'b0;
        fill_tables();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corner words in both modes, no idling
        for (int m = 0; m < 2; m++) begin
            write_mode(t_act_mode'(m));
            for (int i = 0; i < 12; i++)
                pending_pairs.push_back('{gate: corner_gate[i], up: corner_up[i]});
            drain_all();
        end

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 83 : (ph == 3) ? 33 : 0;
            stall_pct = (ph == 2) ? 83 : (ph == 3) ? 33 : 0;
            for (int m = 0; m < 2; m++) begin
                write_mode(t_act_mode'(m));
                queue_random(115);
                drain_all();
                queue_random(115);
                drain_all();
            end
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
